### rtl/core/grc_pkg.sv
// grc_pkg: shared types and constants for the grid ray caster.
// No dependencies.
`default_nettype none
package grc_pkg;
  localparam int MAP_SIZE      = 32;
  localparam int MAP_BITS      = 5;
  localparam int VIEW_COLS     = 640;
  localparam int VIEW_ROWS     = 480;
  localparam int GUARD_STEPS   = 2 * MAP_SIZE + 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  // Command passed from front to back part.
  typedef struct packed {
    logic       opcode;
    logic [9:0] column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [7:0] cell_value;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [8:0]  draw_start;
    logic [8:0]  draw_end;
    logic        hit_side;
    logic [15:0] wall_distance;
    logic [7:0]  hit_cell;
    logic        off_map;
  } res_t;
endpackage
`default_nettype wire

### rtl/core/grc_ram.sv
// grc_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/grc_fifo.sv
// grc_fifo: two-entry command queue between the front and back parts.
// Depends on grc_pkg.
`default_nettype none
module grc_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  grc_pkg::cmd_t    din,
  output logic             full,
  input  wire              pop,
  output grc_pkg::cmd_t    dout,
  output logic             empty
);
  import grc_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= din;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

### rtl/core/grc_div.sv
// grc_div: restoring radix-2 divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module grc_div (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [47:0] num,
  input  wire  [47:0] den,
  output logic        done,
  output logic [47:0] quo
);
  logic [47:0] q_r, q_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [48:0] trial;

  always_comb begin
    trial   = {rem_r[47:0], q_r[47]};
    q_nxt   = {q_r[46:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd48;
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/grc_back.sv
// grc_back: clears the map after reset, then executes commands: map writes, ray setup, DDA walk, span.
// Depends on grc_pkg, grc_ram, grc_div.
`default_nettype none
module grc_back (
  input  wire             clk,
  input  wire             rst_n,
  input  grc_pkg::cmd_t   cmd,
  input  wire             cmd_valid,
  output logic            cmd_pop,
  input  wire  [14:0]     pos_x,
  input  wire  [14:0]     pos_y,
  input  wire  [15:0]     dir_x,
  input  wire  [15:0]     dir_y,
  input  wire  [15:0]     plane_x,
  input  wire  [15:0]     plane_y,
  output grc_pkg::res_t   res,
  output logic            res_valid,
  input  wire             res_ready,
  output logic            busy
);
  import grc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CAM, S_RAY, S_DVX, S_DX, S_DY, S_SIDE, S_WALK, S_RD, S_CHK,
    S_LH, S_OUT
  } state_t;

  localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int ABITS = 2 * MAP_BITS;
  localparam logic [47:0] DELTA_ZERO = 48'h4000_0000_0000;
  localparam logic [47:0] LH_NUM     = 48'(VIEW_ROWS) << 16;
  localparam logic [47:0] LH_CAP     = 48'(2 * VIEW_ROWS);
  localparam logic [8:0]  HALF       = 9'(VIEW_ROWS / 2);
  localparam logic [8:0]  LAST_ROW   = 9'(VIEW_ROWS - 1);

  state_t      state_r;
  cmd_t        c_r;
  logic [ABITS-1:0] clr_r;
  logic [17:0] cam_r;
  logic [47:0] dx_r, dy_r, sx_r, sy_r, perp_r;
  logic [17:0] rx_r, ry_r;
  logic [6:0]  mx_r, my_r;
  logic        side_r, off_r;
  logic [7:0]  cell_r;
  logic [6:0]  guard_r;
  logic        dstart_sel_r;
  res_t        res_r;
  logic        rv_r;

  // cam: floor(column*2^15/640) = floor(column*256/5), by reciprocal of 5
  logic [17:0] col_sh;
  logic [33:0] col_prod;
  logic [24:0] col_div;
  assign col_sh   = {c_r.column, 8'd0};
  assign col_prod = 34'(col_sh) * 34'd52429;
  assign col_div  = 25'(col_prod >> 18);

  // ray products
  logic signed [33:0] prod_x, prod_y;
  assign prod_x = $signed(plane_x) * $signed(cam_r);
  assign prod_y = $signed(plane_y) * $signed(cam_r);

  // divider
  logic        dv_start, dv_done;
  logic [47:0] dv_num, dv_den, dv_quo;
  grc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  logic [17:0] absx, absy;
  assign absx = rx_r[17] ? 18'(-rx_r) : rx_r;
  assign absy = ry_r[17] ? 18'(-ry_r) : ry_r;

  // map RAM
  logic             ram_we;
  logic [ABITS-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  grc_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {c_r.cell_y, c_r.cell_x};
    ram_wdata = c_r.cell_value;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == S_IDLE && cmd_valid && cmd.opcode == OP_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = {cmd.cell_y, cmd.cell_x};
      ram_wdata = cmd.cell_value;
    end
    ram_raddr = {my_r[MAP_BITS-1:0], mx_r[MAP_BITS-1:0]};
  end

  // side distance products: 11-bit frac times delta
  logic [10:0] fx, fy;
  assign fx = rx_r[17] ? {1'b0, pos_x[9:0]} : 11'd1024 - {1'b0, pos_x[9:0]};
  assign fy = ry_r[17] ? {1'b0, pos_y[9:0]} : 11'd1024 - {1'b0, pos_y[9:0]};
  logic [58:0] spx, spy;
  assign spx = 59'(fx) * 59'(dx_r);
  assign spy = 59'(fy) * 59'(dy_r);

  logic        stepx;
  logic [47:0] sx_n, sy_n;
  logic [6:0]  mx_n, my_n;
  assign stepx = sx_r < sy_r;
  assign sx_n  = sx_r + dx_r;
  assign sy_n  = sy_r + dy_r;
  assign mx_n  = rx_r[17] ? mx_r - 7'd1 : mx_r + 7'd1;
  assign my_n  = ry_r[17] ? my_r - 7'd1 : my_r + 7'd1;

  logic [47:0] lh;
  logic [8:0]  lh_half;
  assign lh      = (perp_r == 48'd0 || dv_quo > LH_CAP) ? LH_CAP : dv_quo;
  assign lh_half = 9'(lh[10:1]);

  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign res       = res_r;
  assign res_valid = rv_r;
  assign busy      = (state_r != S_IDLE) || rv_r;

  always_comb begin
    dv_start = 1'b0;
    dv_num   = 48'd1 << 30;
    dv_den   = 48'(absx);
    if (state_r == S_DVX) dv_start = (rx_r != '0);
    if (state_r == S_DX && (dv_done || rx_r == '0)) begin
      dv_start = (ry_r != '0);
      dv_den   = 48'(absy);
    end
    if (state_r == S_CHK && dstart_sel_r) begin
      dv_start = (perp_r != '0);
      dv_num   = LH_NUM;
      dv_den   = perp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      dstart_sel_r <= 1'b0;
      if (rv_r && res_ready) rv_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + ABITS'(1);
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c_r <= cmd;
            if (cmd.opcode == OP_CAST) state_r <= S_CAM;
          end
        end
        S_CAM: begin
          cam_r   <= 18'($signed({1'b0, col_div})) - 18'sd16384;
          state_r <= S_RAY;
        end
        S_RAY: begin
          rx_r    <= 18'($signed(dir_x)) + 18'(prod_x >>> 14);
          ry_r    <= 18'($signed(dir_y)) + 18'(prod_y >>> 14);
          state_r <= S_DVX;
        end
        // ray components are settled; x division starts here
        S_DVX: begin
          state_r <= S_DX;
        end
        S_DX: begin
          if (rx_r == '0 || dv_done) begin
            dx_r    <= (rx_r == '0) ? DELTA_ZERO : dv_quo;
            state_r <= S_DY;
          end
        end
        S_DY: begin
          if (ry_r == '0 || dv_done) begin
            dy_r    <= (ry_r == '0) ? DELTA_ZERO : dv_quo;
            state_r <= S_SIDE;
          end
        end
        S_SIDE: begin
          sx_r    <= 48'(spx >> 10);
          sy_r    <= 48'(spy >> 10);
          mx_r    <= {2'b0, pos_x[14:10]};
          my_r    <= {2'b0, pos_y[14:10]};
          side_r  <= 1'b0;
          perp_r  <= '0;
          cell_r  <= '0;
          guard_r <= '0;
          off_r   <= 1'b0;
          if (pos_x[14:10] >= 5'(MAP_SIZE - 1) + 5'd1 && MAP_SIZE < 32) begin
            off_r <= 1'b1;
          end
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (off_r || guard_r == 7'(GUARD_STEPS)) begin
            off_r        <= 1'b1;
            state_r      <= S_CHK;
            dstart_sel_r <= 1'b1;
          end else begin
            guard_r <= guard_r + 7'd1;
            if (stepx) begin
              sx_r <= sx_n; mx_r <= mx_n; side_r <= 1'b0; perp_r <= sx_r;
              if (mx_n[6:MAP_BITS] != '0) off_r <= 1'b1;
            end else begin
              sy_r <= sy_n; my_r <= my_n; side_r <= 1'b1; perp_r <= sy_r;
              if (my_n[6:MAP_BITS] != '0) off_r <= 1'b1;
            end
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (off_r) begin
            state_r      <= S_CHK;
            dstart_sel_r <= 1'b1;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // RAM data for the stepped cell is valid now
          if (ram_rdata != '0) begin
            cell_r       <= ram_rdata;
            state_r      <= S_CHK;
            dstart_sel_r <= 1'b1;
          end else begin
            state_r <= S_WALK;
          end
        end
        S_CHK: begin
          if (perp_r == '0) state_r <= S_LH;
          else if (dv_done) state_r <= S_LH;
        end
        S_LH: begin
          if (!rv_r) begin
            res_r.out_column    <= c_r.column;
            res_r.draw_start    <= (lh_half > HALF) ? 9'd0 : HALF - lh_half;
            res_r.draw_end      <= (10'(HALF) + 10'(lh_half) > 10'(LAST_ROW))
                                   ? LAST_ROW : HALF + lh_half;
            res_r.hit_side      <= side_r;
            res_r.wall_distance <= (perp_r[47:22] != '0) ? 16'hFFFF : perp_r[21:6];
            res_r.hit_cell      <= off_r ? 8'd0 : cell_r;
            res_r.off_map       <= off_r;
            rv_r                <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/grc_front.sv
// grc_front: accepts input items and holds the camera registers.
// Depends on grc_pkg.
`default_nettype none
module grc_front (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_opcode,
  input  wire  [9:0]      in_column,
  input  wire  [4:0]      in_cell_x,
  input  wire  [4:0]      in_cell_y,
  input  wire  [7:0]      in_cell_value,
  output grc_pkg::cmd_t   cmd,
  input  wire             cfg_we,
  input  wire  [2:0]      cfg_index,
  input  wire  [15:0]     cfg_data,
  output logic [14:0]     pos_x_r,
  output logic [14:0]     pos_y_r,
  output logic [15:0]     dir_x_r,
  output logic [15:0]     dir_y_r,
  output logic [15:0]     plane_x_r,
  output logic [15:0]     plane_y_r
);
  import grc_pkg::*;

  assign cmd = '{opcode: in_opcode, column: in_column, cell_x: in_cell_x,
                 cell_y: in_cell_y, cell_value: in_cell_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= 15'd16896;
      pos_y_r   <= 15'd16896;
      dir_x_r   <= 16'hC000;
      dir_y_r   <= 16'd0;
      plane_x_r <= 16'd0;
      plane_y_r <= 16'd10813;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_X:   pos_x_r   <= cfg_data[14:0];
        REG_POS_Y:   pos_y_r   <= cfg_data[14:0];
        REG_DIR_X:   dir_x_r   <= cfg_data;
        REG_DIR_Y:   dir_y_r   <= cfg_data;
        REG_PLANE_X: plane_x_r <= cfg_data;
        REG_PLANE_Y: plane_y_r <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/grid_ray_cast_column.sv
// grid_ray_cast_column: DDA ray caster, one screen column per cast.
// A cast's run time is set by the serial divider (up to three divisions) and the DDA walk
// (one map RAM read per step). Results wait in an output register.
// Synchronous active-low reset; after reset the map's 1024 cells are cleared, during
// which up to two items queue at the input but none is executed.
`default_nettype none
module grid_ray_cast_column (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  output logic        full,
  input  wire         in_opcode,
  input  wire  [9:0]  in_column,
  input  wire  [4:0]  in_cell_x,
  input  wire  [4:0]  in_cell_y,
  input  wire  [7:0]  in_cell_value,
  output logic        empty,
  input  wire         pop,
  output logic [9:0]  out_column,
  output logic [8:0]  out_draw_start,
  output logic [8:0]  out_draw_end,
  output logic        out_hit_side,
  output logic [15:0] out_wall_distance,
  output logic [7:0]  out_hit_cell,
  output logic        out_off_map,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import grc_pkg::*;

  cmd_t        in_cmd, q_cmd;
  logic        q_full, q_empty, q_pop;
  logic [14:0] pos_x, pos_y;
  logic [15:0] dir_x, dir_y, plane_x, plane_y;
  res_t        res;
  logic        res_valid, busy;

  grc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_opcode(in_opcode),
    .in_column(in_column), .in_cell_x(in_cell_x), .in_cell_y(in_cell_y),
    .in_cell_value(in_cell_value), .cmd(in_cmd), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .pos_x_r(pos_x),
    .pos_y_r(pos_y), .dir_x_r(dir_x), .dir_y_r(dir_y), .plane_x_r(plane_x),
    .plane_y_r(plane_y)
  );

  grc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(in_push), .din(in_cmd), .full(q_full),
    .pop(q_pop), .dout(q_cmd), .empty(q_empty)
  );

  grc_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd(q_cmd), .cmd_valid(!q_empty),
    .cmd_pop(q_pop), .pos_x(pos_x), .pos_y(pos_y), .dir_x(dir_x),
    .dir_y(dir_y), .plane_x(plane_x), .plane_y(plane_y), .res(res),
    .res_valid(res_valid), .res_ready(pop), .busy(busy)
  );

  assign full              = q_full;
  assign empty             = !res_valid;
  assign out_column        = res.out_column;
  assign out_draw_start    = res.draw_start;
  assign out_draw_end      = res.draw_end;
  assign out_hit_side      = res.hit_side;
  assign out_wall_distance = res.wall_distance;
  assign out_hit_cell      = res.hit_cell;
  assign out_off_map       = res.off_map;

`ifndef SYNTHESIS
  a_off_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_off_map && out_hit_cell != 8'd0))
    else $error("off-map result carries a cell");
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_draw_start <= out_draw_end)
    else $error("span inverted");
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> busy)
    else $error("result pending while back part reports idle");
`endif
endmodule
`default_nettype wire

### bench/tb_grid_ray_cast_column.sv
// tb_grid_ray_cast_column: self-checking bench for the DDA column ray caster.
// Depends on grc_pkg and grid_ray_cast_column; predicts each cast in place.
`timescale 1ns / 100ps
module tb_grid_ray_cast_column;
  import grc_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        full;
  logic        in_opcode = OP_WRITE;
  logic [9:0]  in_column = '0;
  logic [4:0]  in_cell_x = '0;
  logic [4:0]  in_cell_y = '0;
  logic [7:0]  in_cell_value = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [9:0]  out_column;
  logic [8:0]  out_draw_start;
  logic [8:0]  out_draw_end;
  logic        out_hit_side;
  logic [15:0] out_wall_distance;
  logic [7:0]  out_hit_cell;
  logic        out_off_map;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  grid_ray_cast_column dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model state
  logic [7:0]  tile_map [MAP_SIZE*MAP_SIZE];
  logic [14:0] cam_pos_x, cam_pos_y;
  logic signed [15:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;

  res_t expected_columns [$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   hold_off = 1'b0;
  bit   stall_off = 1'b0;
  int   stall_pct = 30;

  function automatic logic [63:0] delta_for(longint r);
    longint a;
    if (r == 0) return 64'd1 << 46;
    a = (r < 0) ? -r : r;
    return (64'd1 << 30) / a;
  endfunction

  function automatic res_t cast_column(logic [9:0] col);
    res_t   res;
    longint cam, rx, ry, mx, my, stx, sty, dstart, dend, px, py;
    logic [63:0] dx, dy, sx, sy, perp, lh;
    logic [7:0] hit;
    bit side, off;
    cam = longint'((64'(col) * 32768) / VIEW_COLS) - 16384;
    px = longint'(cam_plane_x) * cam;
    py = longint'(cam_plane_y) * cam;
    rx = longint'(cam_dir_x) + (px >>> 14);
    ry = longint'(cam_dir_y) + (py >>> 14);
    dx = delta_for(rx);
    dy = delta_for(ry);
    mx = cam_pos_x >> 10;
    my = cam_pos_y >> 10;
    perp = 0; side = 0; off = 0; hit = 0;
    if (rx < 0) begin stx = -1; sx = (64'(cam_pos_x[9:0]) * dx) >> 10; end
    else begin stx = 1; sx = ((64'd1024 - cam_pos_x[9:0]) * dx) >> 10; end
    if (ry < 0) begin sty = -1; sy = (64'(cam_pos_y[9:0]) * dy) >> 10; end
    else begin sty = 1; sy = ((64'd1024 - cam_pos_y[9:0]) * dy) >> 10; end
    if (mx >= MAP_SIZE || my >= MAP_SIZE) begin
      off = 1;
    end else begin
      for (int g = 0; g < GUARD_STEPS; g++) begin
        if (sx < sy) begin
          sx += dx; mx += stx; side = 0; perp = sx - dx;
        end else begin
          sy += dy; my += sty; side = 1; perp = sy - dy;
        end
        if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE) begin
          off = 1;
          break;
        end
        hit = tile_map[my*MAP_SIZE + mx];
        if (hit != 0) break;
      end
      if (hit == 0) off = 1;
    end
    if (perp == 0) lh = 2*VIEW_ROWS;
    else begin
      lh = (64'(VIEW_ROWS) << 16) / perp;
      if (lh > 2*VIEW_ROWS) lh = 2*VIEW_ROWS;
    end
    dstart = VIEW_ROWS/2 - longint'(lh/2);
    if (dstart < 0) dstart = 0;
    dend = VIEW_ROWS/2 + longint'(lh/2);
    if (dend >= VIEW_ROWS) dend = VIEW_ROWS - 1;
    res.out_column    = col;
    res.draw_start    = dstart[8:0];
    res.draw_end      = dend[8:0];
    res.hit_side      = side;
    res.wall_distance = ((perp >> 6) > 65535) ? 16'hFFFF : perp[21:6];
    res.hit_cell      = off ? 8'd0 : hit;
    res.off_map       = off;
    return res;
  endfunction

  // One transfer on the input side; prediction happens at acceptance.
  task automatic send_item(logic op, logic [9:0] col, logic [4:0] cx, logic [4:0] cy,
                           logic [7:0] val);
    in_push       <= 1'b1;
    in_opcode     <= op;
    in_column     <= col;
    in_cell_x     <= cx;
    in_cell_y     <= cy;
    in_cell_value <= val;
    do @(posedge clk); while (full);
    if (op == OP_WRITE) tile_map[{cy, cx}] = val;
    else expected_columns.push_back(cast_column(col));
  endtask

  task automatic idle_input(int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_write(logic [4:0] cx, logic [4:0] cy, logic [7:0] val);
    send_item(OP_WRITE, 10'($urandom), cx, cy, val);
  endtask

  task automatic send_cast(logic [9:0] col);
    send_item(OP_CAST, col, 5'($urandom), 5'($urandom), 8'($urandom));
  endtask

  // Bursty sender between items
  task automatic maybe_gap();
    if ($urandom_range(0, 7) == 0) idle_input($urandom_range(1, 12));
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
    // a trailing write may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_POS_X:   cam_pos_x   = val[14:0];
      REG_POS_Y:   cam_pos_y   = val[14:0];
      REG_DIR_X:   cam_dir_x   = val;
      REG_DIR_Y:   cam_dir_y   = val;
      REG_PLANE_X: cam_plane_x = val;
      REG_PLANE_Y: cam_plane_y = val;
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [14:0] px, logic [14:0] py, logic [15:0] dx,
                            logic [15:0] dy, logic [15:0] plx, logic [15:0] ply);
    write_reg(REG_POS_X, {1'b0, px});
    write_reg(REG_POS_Y, {1'b0, py});
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_PLANE_X, plx);
    write_reg(REG_PLANE_Y, ply);
    cfg_we <= 1'b0;
  endtask

  // Border walls with random nonzero cell values
  task automatic build_room();
    for (int i = 0; i < MAP_SIZE; i++) begin
      send_write(5'(i), 5'd0, 8'($urandom_range(1, 255)));
      send_write(5'(i), 5'(MAP_SIZE-1), 8'($urandom_range(1, 255)));
      send_write(5'd0, 5'(i), 8'($urandom_range(1, 255)));
      send_write(5'(MAP_SIZE-1), 5'(i), 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_directed();
    // open map at reset camera: ray leaves the map
    send_cast(10'd0);
    send_cast(10'd639);
    send_cast(10'd320);
    send_cast(10'd1023);          // column past the screen
    send_write(5'd16, 5'd16, 8'd0);
    send_write(5'd31, 5'd31, 8'hFF);
    build_room();
    send_cast(10'd0);
    send_cast(10'd320);
    send_cast(10'd639);
    send_cast(10'd1023);
    drain();
    // viewer in the corner cell at the far edge of the map
    set_camera(15'h7FFF, 15'h7FFF, 16'h4000, 16'h0000, 16'h0000, 16'h2A3D);
    send_cast(10'd320);
    drain();
    // viewer inside a wall cell: zero distance
    set_camera(15'd0, 15'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_cast(10'd0);
    send_cast(10'd700);
    drain();
    // axis-aligned ray: zero component
    set_camera(15'd16896, 15'd16896, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_cast(10'd320);
    send_cast(10'd5);
    drain();
  endtask

  task automatic test_random_casts(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) send_cast(10'($urandom_range(0, 639)));
      else if ($urandom_range(0, 3) == 0) send_cast(10'($urandom));
      else send_write(5'($urandom), 5'($urandom),
                      ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom));
      maybe_gap();
    end
    drain();
  endtask

  task automatic test_random_cameras(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      set_camera(15'($urandom_range(1024, 31*1024)), 15'($urandom_range(1024, 31*1024)),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      test_random_casts(per_phase);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (2) @(posedge clk);
    hold_off = 1'b0;
    for (int i = 0; i < 20; i++) send_cast(10'($urandom_range(0, 639)));
    drain();
  endtask

  // Receiver: random stall pattern plus a long hold-off window
  always @(posedge clk) begin
    int hold_cycles;
    if (hold_off) hold_cycles = 3000;
    if (!rst_n) pop <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles--;
      pop <= 1'b0;
    end else if (stall_off) pop <= 1'b1;
    else pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && pop && !empty) begin
      if (expected_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, column %0d", out_column);
      end else begin
        exp_r = expected_columns.pop_front();
        if (exp_r.out_column !== out_column || exp_r.draw_start !== out_draw_start ||
            exp_r.draw_end !== out_draw_end || exp_r.hit_side !== out_hit_side ||
            exp_r.wall_distance !== out_wall_distance ||
            exp_r.hit_cell !== out_hit_cell || exp_r.off_map !== out_off_map) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp col %0d %0d..%0d side %0d dist %0d cell %0d off %0d",
                     exp_r.out_column, exp_r.draw_start, exp_r.draw_end, exp_r.hit_side,
                     exp_r.wall_distance, exp_r.hit_cell, exp_r.off_map,
                     " | got col %0d %0d..%0d side %0d dist %0d cell %0d off %0d",
                     out_column, out_draw_start, out_draw_end, out_hit_side,
                     out_wall_distance, out_hit_cell, out_off_map);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAP_SIZE*MAP_SIZE; i++) tile_map[i] = '0;
    cam_pos_x = 15'd16896; cam_pos_y = 15'd16896;
    cam_dir_x = -16'sd16384; cam_dir_y = '0;
    cam_plane_x = '0; cam_plane_y = 16'sd10813;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    stall_off = 1'b1;
    test_random_casts(200);
    stall_off = 1'b0;
    stall_pct = 70;
    test_random_cameras(8, 100);
    stall_pct = 30;
    test_backpressure();
    test_random_cameras(4, 150);
    set_camera(15'd0, 15'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    test_random_casts(60);
    set_camera(15'h7FFF, 15'h7BFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    test_random_casts(60);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_columns.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

### grid_ray_cast_column.f
rtl/core/grc_pkg.sv
rtl/core/grc_ram.sv
rtl/core/grc_fifo.sv
rtl/core/grc_div.sv
rtl/core/grc_back.sv
rtl/core/grc_front.sv
rtl/core/grid_ray_cast_column.sv
bench/tb_grid_ray_cast_column.sv
